/* hdl/pcx_rle_pkg.sv */
package pcx_rle_pkg;

   localparam int MAX_DIM  = 4096;
   localparam int DIM_W    = $clog2(MAX_DIM + 1);
   localparam int POS_W    = $clog2(MAX_DIM);
   localparam int CFG_W    = 13;
   localparam int PLANE_W  = 2;
   localparam int BYTE_W   = 8;
   localparam int CNT_W    = 6;
   localparam int ADDR_W   = 26;
   localparam int RSP_W    = ((ADDR_W + BYTE_W + 7) / 8) * 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [BYTE_W-1:0] MARKER_MASK = 8'hC0;
   localparam logic [BYTE_W-1:0] COUNT_MASK  = 8'h3F;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_PLANE_COUNT  = 2'd2,
      CSR_LINE_BYTES   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_FLUSH
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic flush;
   } ctl_cmd_type;

   typedef struct packed {
      logic start;
      logic emit;
      logic last_iter;
      logic hold_valid;
      logic out_free;
   } ctl_status_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         return DIM_W'(MAX_DIM);
      end else begin
         return DIM_W'(v);
      end
   endfunction

endpackage

/* hdl/pcx_rle_ctl.sv */
module pcx_rle_ctl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  pcx_rle_pkg::ctl_status_type status,
   output pcx_rle_pkg::ctl_cmd_type    cmd
);
   import pcx_rle_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          step_go;
   logic          flush_go;

   assign step_go  = (state_ff == ST_STEP) &&
                     !(status.emit && status.hold_valid && !status.out_free);
   assign flush_go = (state_ff == ST_FLUSH) && (!status.hold_valid || status.out_free);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && status.start) state_in = ST_STEP;
         end
         ST_STEP: begin
            if (step_go && status.last_iter) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (flush_go) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      cmd.load   = (state_ff == ST_IDLE) && req_tvalid;
      cmd.step   = step_go;
      cmd.flush  = flush_go;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hdl/pcx_rle_dp.sv */
module pcx_rle_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [pcx_rle_pkg::BYTE_W-1:0]        req_tdata,
   input  logic                                  csr_we,
   input  logic [pcx_rle_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pcx_rle_pkg::CFG_W-1:0]         csr_wdata,
   input  pcx_rle_pkg::ctl_cmd_type              cmd,
   output pcx_rle_pkg::ctl_status_type           status,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [pcx_rle_pkg::RSP_W-1:0]         rsp_tdata,
   output logic                                  rsp_tlast,
   output logic                                  rsp_tuser
);
   import pcx_rle_pkg::*;

   // configuration
   logic [CFG_W-1:0]   width_ff, height_ff, lbytes_ff;
   logic [PLANE_W-1:0] planes_ff;

   // decode state
   logic               pending_ff, pending_in;
   logic [CNT_W-1:0]   run_len_ff, run_len_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic [POS_W-1:0]   col_ff, col_in;
   logic [PLANE_W-1:0] plane_ff, plane_in;
   logic [POS_W-1:0]   row_ff, row_in;
   logic [ADDR_W-1:0]  row_base_ff, row_base_in;
   logic               finished_ff, finished_in;

   // held result of the current byte, not yet known to be its last
   logic               hold_valid_ff, hold_valid_in;
   logic [BYTE_W-1:0]  hold_value_ff, hold_value_in;
   logic [ADDR_W-1:0]  hold_addr_ff, hold_addr_in;
   logic               hold_done_ff, hold_done_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]  out_value_ff, out_value_in;
   logic [ADDR_W-1:0]  out_addr_ff, out_addr_in;
   logic               out_last_ff, out_last_in;
   logic               out_done_ff, out_done_in;

   logic [DIM_W-1:0]     w_eff, h_eff, lb_eff, last_col;
   logic [PLANE_W-1:0]   np_eff;
   logic                 is_marker;
   logic [DIM_W-1:0]     col_inc, row_inc;
   logic [PLANE_W:0]     plane_inc;
   logic                 col_wrap, plane_wrap, row_end;
   logic                 emit, done_now, out_free, out_push;
   logic [DIM_W+PLANE_W-1:0] plane_off, row_stride;
   logic [ADDR_W-1:0]    addr_now;

   assign w_eff    = clamp_dim(width_ff);
   assign h_eff    = clamp_dim(height_ff);
   assign lb_eff   = clamp_dim(lbytes_ff);
   assign np_eff   = (planes_ff == '0) ? PLANE_W'(1) : planes_ff;
   assign last_col = ((w_eff < lb_eff) ? w_eff : lb_eff) - DIM_W'(1);

   assign is_marker  = (req_tdata & MARKER_MASK) == MARKER_MASK;
   assign col_inc    = DIM_W'(col_ff) + DIM_W'(1);
   assign row_inc    = DIM_W'(row_ff) + DIM_W'(1);
   assign plane_inc  = {1'b0, plane_ff} + (PLANE_W+1)'(1);
   assign col_wrap   = col_inc >= lb_eff;
   assign plane_wrap = plane_inc >= {1'b0, np_eff};
   assign row_end    = row_inc >= h_eff;

   assign emit       = DIM_W'(col_ff) < w_eff;
   assign plane_off  = (DIM_W+PLANE_W)'(plane_ff) * (DIM_W+PLANE_W)'(w_eff);
   assign row_stride = (DIM_W+PLANE_W)'(np_eff) * (DIM_W+PLANE_W)'(w_eff);
   assign addr_now   = row_base_ff + ADDR_W'(plane_off) + ADDR_W'(col_ff);
   assign done_now   = (DIM_W'(row_ff) == h_eff - DIM_W'(1)) &&
                       (plane_ff == np_eff - PLANE_W'(1)) &&
                       (DIM_W'(col_ff) == last_col);

   assign out_free = !out_valid_ff || rsp_tready;
   assign out_push = (cmd.step && emit && hold_valid_ff) || (cmd.flush && hold_valid_ff);

   always_comb begin
      status.start      = !finished_ff && !(is_marker && !pending_ff) &&
                          (!pending_ff || (run_len_ff != '0));
      status.emit       = emit;
      status.last_iter  = (cnt_ff == CNT_W'(1)) || (col_wrap && plane_wrap && row_end);
      status.hold_valid = hold_valid_ff;
      status.out_free   = out_free;
   end

   always_comb begin
      pending_in    = pending_ff;
      run_len_in    = run_len_ff;
      cnt_in        = cnt_ff;
      byte_in       = byte_ff;
      col_in        = col_ff;
      plane_in      = plane_ff;
      row_in        = row_ff;
      row_base_in   = row_base_ff;
      finished_in   = finished_ff;
      hold_valid_in = hold_valid_ff;
      hold_value_in = hold_value_ff;
      hold_addr_in  = hold_addr_ff;
      hold_done_in  = hold_done_ff;

      if (cmd.load && !finished_ff) begin
         byte_in = req_tdata;
         if (!pending_ff && is_marker) begin
            pending_in = 1'b1;
            run_len_in = CNT_W'(req_tdata & COUNT_MASK);
         end else begin
            cnt_in     = pending_ff ? run_len_ff : CNT_W'(1);
            pending_in = 1'b0;
            run_len_in = '0;
         end
      end

      if (cmd.step) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (emit) begin
            hold_valid_in = 1'b1;
            hold_value_in = byte_ff;
            hold_addr_in  = addr_now;
            hold_done_in  = done_now;
         end
         if (col_wrap) begin
            col_in = '0;
            if (plane_wrap) begin
               plane_in    = '0;
               row_base_in = row_base_ff + ADDR_W'(row_stride);
               row_in      = POS_W'(row_inc);
               if (row_end) finished_in = 1'b1;
            end else begin
               plane_in = PLANE_W'(plane_inc);
            end
         end else begin
            col_in = POS_W'(col_inc);
         end
      end

      if (cmd.flush) hold_valid_in = 1'b0;
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_value_in = out_value_ff;
      out_addr_in  = out_addr_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      if (out_push) begin
         out_valid_in = 1'b1;
         out_value_in = hold_value_ff;
         out_addr_in  = hold_addr_ff;
         out_last_in  = cmd.flush;
         out_done_in  = hold_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(1);
         height_ff <= CFG_W'(1);
         planes_ff <= PLANE_W'(1);
         lbytes_ff <= CFG_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            CSR_PLANE_COUNT:  planes_ff <= csr_wdata[PLANE_W-1:0];
            CSR_LINE_BYTES:   lbytes_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= 1'b0;
         run_len_ff    <= '0;
         cnt_ff        <= '0;
         col_ff        <= '0;
         plane_ff      <= '0;
         row_ff        <= '0;
         row_base_ff   <= '0;
         finished_ff   <= 1'b0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pending_ff    <= pending_in;
         run_len_ff    <= run_len_in;
         cnt_ff        <= cnt_in;
         col_ff        <= col_in;
         plane_ff      <= plane_in;
         row_ff        <= row_in;
         row_base_ff   <= row_base_in;
         finished_ff   <= finished_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      hold_value_ff <= hold_value_in;
      hold_addr_ff  <= hold_addr_in;
      hold_done_ff  <= hold_done_in;
      out_value_ff  <= out_value_in;
      out_addr_ff   <= out_addr_in;
      out_last_ff   <= out_last_in;
      out_done_ff   <= out_done_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_W - ADDR_W - BYTE_W)'(0), out_addr_ff, out_value_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_done_ff;

   a_push_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_push |-> out_free)
      else $error("output register overwritten while stalled");

   a_no_step_after_end: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (!finished_ff && (cnt_ff != '0)))
      else $error("iteration issued with no work left");

   a_flush_empties_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> !hold_valid_ff)
      else $error("held result survived end of byte");

endmodule

/* hdl/pcx_rle_image_decoder.sv */
// pcx run-length image decoder
// req_* carries the compressed stream, one byte per word. a byte with both
// top bits set is a run marker whose low six bits repeat the next byte;
// any other byte is a single literal. each decoded byte is placed on a
// scan line of plane_count planes of line_bytes bytes, and bytes in columns
// below image_width leave on rsp_* with their linear output address.
// rsp_tlast marks the final word caused by one input byte, rsp_tuser the
// word that completes the last row. bytes after the last row are taken and
// dropped. csr_* writes the four geometry registers while the block is idle;
// the user must keep to this, as the block itself has no guard for it. a
// marker or dropped byte is taken in idle alone; a repeated byte takes one
// iteration of the position counters per repeat, then a flush to hand over
// the held last word. each word passes the held and output registers, and
// the single position/address unit takes a new byte only after the flush.
// reset returns all geometry registers to 1 and clears the position.
// a stalled receiver holds the output register, which stops the run after
// at most one further word and stops intake until it drains.
module pcx_rle_image_decoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pcx_rle_pkg::BYTE_W-1:0]    req_tdata,   // data_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pcx_rle_pkg::RSP_W-1:0]     rsp_tdata,   // pixel_value, pixel_address
   output logic                              rsp_tlast,   // last_of_run
   output logic                              rsp_tuser,   // image_done
   input  logic                              csr_we,
   input  logic [pcx_rle_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pcx_rle_pkg::CFG_W-1:0]     csr_wdata
);
   import pcx_rle_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   pcx_rle_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pcx_rle_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* tb/sv/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pcx_rle_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic [ADDR_W-1:0] addr;
      logic              last;
      logic              done;
   } pixel_word_type;

   function automatic int unsigned dim_limit(logic [CFG_W-1:0] v);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > MAX_DIM) begin
         return MAX_DIM;
      end
      return int'(v);
   endfunction

   class pixel_book;
      logic [CFG_W-1:0]   width_reg;
      logic [CFG_W-1:0]   height_reg;
      logic [PLANE_W-1:0] planes_reg;
      logic [CFG_W-1:0]   line_reg;
      bit                 run_armed;
      bit [CNT_W-1:0]     repeat_cnt;
      int unsigned        col;
      int unsigned        plane;
      int unsigned        row;
      bit [ADDR_W-1:0]    row_base;
      bit                 image_over;
      pixel_word_type     pending_pixels[$];
      int unsigned        mismatches;

      function new();
         width_reg  = 1;
         height_reg = 1;
         planes_reg = 1;
         line_reg   = 1;
         run_armed  = 0;
         repeat_cnt = 0;
         col        = 0;
         plane      = 0;
         row        = 0;
         row_base   = 0;
         image_over = 0;
         mismatches = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CFG_W-1:0] v);
         case (idx)
            CSR_IMAGE_WIDTH:  width_reg  = v;
            CSR_IMAGE_HEIGHT: height_reg = v;
            CSR_PLANE_COUNT:  planes_reg = v[PLANE_W-1:0];
            CSR_LINE_BYTES:   line_reg   = v;
            default: ;
         endcase
      endfunction

      // decode one accepted stream byte into the pixels it places
      function void take_byte(logic [BYTE_W-1:0] b);
         int unsigned w;
         int unsigned h;
         int unsigned lb;
         int unsigned np;
         int unsigned last_col;
         int unsigned reps;
         pixel_word_type held;
         bit          have_held;
         have_held = 0;
         held      = '0;
         w  = dim_limit(width_reg);
         h  = dim_limit(height_reg);
         lb = dim_limit(line_reg);
         np = (planes_reg == '0) ? 1 : int'(planes_reg);
         last_col = ((w < lb) ? w : lb) - 1;
         if (image_over) begin
            return;
         end
         if (!run_armed && (b & MARKER_MASK) == MARKER_MASK) begin
            run_armed  = 1;
            repeat_cnt = b[CNT_W-1:0];
            return;
         end
         reps = run_armed ? int'(repeat_cnt) : 1;
         run_armed  = 0;
         repeat_cnt = 0;
         for (int unsigned i = 0; i < reps && !image_over; i++) begin
            if (col < w) begin
               if (have_held) begin
                  pending_pixels.push_back(held);
               end
               held.value = b;
               held.addr  = ADDR_W'(row_base + plane * w + col);
               held.last  = 1'b0;
               held.done  = (row == h - 1) && (plane == np - 1) && (col == last_col);
               have_held  = 1;
            end
            col++;
            if (col >= lb) begin
               col = 0;
               plane++;
               if (plane >= np) begin
                  plane    = 0;
                  row_base = ADDR_W'(row_base + w * np);
                  row++;
                  if (row >= h) begin
                     image_over = 1;
                  end
               end
            end
         end
         if (have_held) begin
            held.last = 1'b1;
            pending_pixels.push_back(held);
         end
      endfunction

      function void match_pixel(pixel_word_type got);
         pixel_word_type want;
         if (pending_pixels.size() == 0) begin
            $display("%0t: word expected none actual value=%h addr=%h last=%b done=%b",
                     $time, got.value, got.addr, got.last, got.done);
            mismatches++;
            return;
         end
         want = pending_pixels.pop_front();
         if (got.value !== want.value) begin
            $display("%0t: pixel_value expected %h actual %h", $time, want.value, got.value);
            mismatches++;
         end
         if (got.addr !== want.addr) begin
            $display("%0t: pixel_address expected %h actual %h", $time, want.addr, got.addr);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last_of_run expected %b actual %b", $time, want.last, got.last);
            mismatches++;
         end
         if (got.done !== want.done) begin
            $display("%0t: image_done expected %b actual %b", $time, want.done, got.done);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [BYTE_W-1:0]    req_tdata  = '0;   // data_byte
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;         // pixel_value, pixel_address
   logic                 rsp_tlast;         // last_of_run
   logic                 rsp_tuser;         // image_done
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CFG_W-1:0]     csr_wdata  = '0;

   pixel_book book;
   bit        req_calm;
   bit        rsp_calm;

   pcx_rle_image_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic int unsigned pause_len(inout bit calm);
      if ($urandom_range(0, 15) == 0) begin
         calm = !calm;
      end
      return calm ? 0 : $urandom_range(0, 3);
   endfunction

   task automatic push_byte(logic [BYTE_W-1:0] b);
      int unsigned gap;
      gap = pause_len(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      book.take_byte(b);
   endtask

   task automatic put_reg(csr_index_type idx, int unsigned v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CFG_W'(v);
      @(posedge clock);
      book.write_reg(idx, CFG_W'(v));
   endtask

   task automatic set_geometry(int unsigned w, int unsigned h, int unsigned p,
                               int unsigned lb);
      put_reg(CSR_IMAGE_WIDTH, w);
      put_reg(CSR_IMAGE_HEIGHT, h);
      put_reg(CSR_PLANE_COUNT, p);
      put_reg(CSR_LINE_BYTES, lb);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // drain all pixels, then leave room for a marker or dropped byte in flight
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (book.pending_pixels.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic random_stream(int unsigned count);
      int unsigned    sent;
      int unsigned    pick;
      bit [CNT_W-1:0] run_len;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            push_byte(BYTE_W'($urandom_range(0, 191)));
            sent += 1;
         end else if (pick < 9) begin
            run_len = $urandom_range(0, 1) ? CNT_W'($urandom_range(0, 63))
                                           : CNT_W'($urandom_range(0, 7));
            push_byte({2'b11, run_len});
            push_byte(BYTE_W'($urandom_range(0, 255)));
            sent += 2;
         end else begin
            push_byte(BYTE_W'($urandom_range(0, 255)));
            sent += 1;
         end
      end
   endtask

   initial begin : drain_side
      pixel_word_type got;
      int unsigned gap;
      wait (reset === 1'b0);
      forever begin
         gap = pause_len(rsp_calm);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         got.value = rsp_tdata[BYTE_W-1:0];
         got.addr  = rsp_tdata[BYTE_W +: ADDR_W];
         got.last  = rsp_tlast;
         got.done  = rsp_tuser;
         book.match_pixel(got);
      end
   end

   initial begin : stimulus
      book = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // three planes with padding columns
      set_geometry(5, 8191, 3, 6);
      push_byte(8'h00);
      push_byte(8'hBF);
      push_byte(8'h80);
      push_byte(8'h7F);
      // zero-count run
      push_byte(8'hC0);
      push_byte(8'h55);
      // full run of a marker-looking byte, crosses several lines
      push_byte(8'hFF);
      push_byte(8'hFF);
      push_byte(8'hC1);
      push_byte(8'hC0);
      push_byte(8'hC2);
      push_byte(8'h01);
      push_byte(8'h40);
      push_byte(8'h3F);
      random_stream(90);
      settle();

      set_geometry(0, 4096, 1, 8);
      random_stream(90);
      settle();

      set_geometry(8191, 4000, 2, 8191);
      random_stream(60);
      settle();

      // width above line length
      set_geometry(12, 4096, 3, 4);
      random_stream(90);
      settle();

      set_geometry(3, 4096, 0, 0);
      random_stream(60);
      settle();

      // run the image to its end, then feed bytes that must be dropped
      set_geometry(10, book.row + 2, 3, 6);
      while (!book.image_over) begin
         push_byte({2'b11, 6'($urandom_range(20, 63))});
         push_byte(BYTE_W'($urandom_range(0, 255)));
      end
      push_byte(8'hC5);
      push_byte(8'h11);
      push_byte(8'h22);
      settle();

      set_geometry(0, 0, 1, 5);
      repeat (12) push_byte(BYTE_W'($urandom_range(0, 255)));
      settle();

      if (book.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
